>>> rtl/core/cstrr_pkg.sv
// types and codes shared by the client/server table files
package cstrr_pkg;

  localparam logic [2:0] ACT_IGNORED   = 3'd0;
  localparam logic [2:0] ACT_UNCHANGED = 3'd1;
  localparam logic [2:0] ACT_MODIFIED  = 3'd2;
  localparam logic [2:0] ACT_INSERTED  = 3'd3;
  localparam logic [2:0] ACT_REPLACED  = 3'd4;

  localparam int unsigned ADDR_W = 32;

  typedef struct packed {
    logic              is_tcp;
    logic              has_payload;
    logic              established_original;
    logic [ADDR_W-1:0] client_addr;
    logic [ADDR_W-1:0] server_addr;
    logic [ADDR_W-1:0] gateway_candidate;
  } req_t;

  typedef struct packed {
    logic              table_changed;
    logic [2:0]        action;
    logic [3:0]        slot_index;
    logic [ADDR_W-1:0] gateway_addr;
  } rsp_t;

endpackage

>>> rtl/core/cstrr_ram.sv
// generic single-port-write, registered-read ram
module cstrr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/client_server_table_round_robin.sv
// top level: client/server address table with round-robin replacement
//
// usage:
//   req carries one packet item per valid/ready handshake. rsp returns
//   exactly one result item per request, in order, on its own valid/ready
//   channel.
//   an item that is not a TCP packet with payload on an established
//   connection in the original direction skips the scan and goes straight
//   to the finish state, and its result is offered from there.
//   a qualifying item scans the table one entry per cycle from entry 0
//   through a ram with a registered read; it finishes at the first
//   matching or empty entry. when the table is full, the round-robin
//   entry is replaced. one item is worked on at a time; the next item can
//   be taken in the same cycle that a result is offered.
//   the result sits in an output register, so a new item is taken while a
//   finished result still waits; a stalled receiver holds the next result
//   in its finish state and blocks further items until the register frees.
//   reset clears the per-entry valid flags (the table reads as all zero),
//   the round-robin pointer and the gateway register at once; no sweep.
module client_server_table_round_robin #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  cstrr_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output cstrr_pkg::rsp_t  rsp
);

  localparam int unsigned IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned AW   = cstrr_pkg::ADDR_W;
  localparam logic [IDXW-1:0] LAST = IDXW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state;
  logic [IDXW-1:0]    ridx;
  logic               iss;
  logic [IDXW-1:0]    chk_idx;
  logic               chk_vld;
  logic [IDXW-1:0]    rr_ptr;
  logic [AW-1:0]      gateway;
  logic [ENTRIES-1:0] vld;
  logic [AW-1:0]      cur_client;
  logic [AW-1:0]      cur_server;
  cstrr_pkg::rsp_t    res;

  logic               accept;
  logic               qualify;
  logic [AW-1:0]      gateway_next;
  logic [2*AW-1:0]    rd_data;
  logic [AW-1:0]      entry_key;
  logic [AW-1:0]      entry_srv;
  logic               hit;
  logic               empty;
  logic               full_end;
  logic               decide;
  logic               wr_en;
  logic [IDXW-1:0]    wr_addr;
  logic               out_free;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign qualify   = req.is_tcp && req.has_payload && req.established_original;
  assign gateway_next = (gateway == '0) ? req.gateway_candidate : gateway;
  assign out_free  = !rsp_valid || rsp_ready;

  cstrr_ram #(
    .WIDTH (2 * AW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({cur_client, cur_server}),
    .rd_en   (iss && (state == S_SCAN)),
    .rd_addr (ridx),
    .rd_data (rd_data)
  );

  assign entry_key = vld[chk_idx] ? rd_data[2*AW-1:AW] : '0;
  assign entry_srv = vld[chk_idx] ? rd_data[AW-1:0] : '0;

  always_comb begin
    hit      = (state == S_SCAN) && chk_vld && (entry_key == cur_client);
    empty    = (state == S_SCAN) && chk_vld && !hit && (entry_key == '0);
    full_end = (state == S_SCAN) && chk_vld && !hit && !empty && (chk_idx == LAST);
    decide   = hit || empty || full_end;
    wr_en    = (hit && (entry_srv != cur_server)) || empty || full_end;
    wr_addr  = full_end ? rr_ptr : chk_idx;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ridx      <= '0;
      iss       <= 1'b0;
      chk_idx   <= '0;
      chk_vld   <= 1'b0;
      rr_ptr    <= '0;
      gateway   <= '0;
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            ridx    <= '0;
            chk_vld <= 1'b0;
            if (qualify) begin
              gateway <= gateway_next;
              iss     <= 1'b1;
              state   <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (decide) begin
            iss     <= 1'b0;
            chk_vld <= 1'b0;
            state   <= S_DONE;
            if (full_end) begin
              rr_ptr <= (rr_ptr == LAST) ? '0 : rr_ptr + 1'b1;
            end
          end else begin
            chk_vld <= iss;
            chk_idx <= ridx;
            if (iss) begin
              if (ridx == LAST) begin
                iss <= 1'b0;
              end else begin
                ridx <= ridx + 1'b1;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_client <= req.client_addr;
      cur_server <= req.server_addr;
      res.table_changed <= 1'b0;
      res.action        <= cstrr_pkg::ACT_IGNORED;
      res.slot_index    <= '0;
      res.gateway_addr  <= qualify ? gateway_next : gateway;
    end
    if (decide) begin
      res.table_changed <= wr_en;
      res.slot_index    <= 4'(wr_addr);
      if (hit) begin
        res.action <= (entry_srv != cur_server) ? cstrr_pkg::ACT_MODIFIED
                                                : cstrr_pkg::ACT_UNCHANGED;
      end else if (empty) begin
        res.action <= cstrr_pkg::ACT_INSERTED;
      end else begin
        res.action <= cstrr_pkg::ACT_REPLACED;
      end
    end
    if ((state == S_DONE) && out_free) begin
      rsp <= res;
    end
  end

endmodule

>>> rtl/core/cstrr_checker.sv
// port-level checks for the client/server table, bound to the top level
module cstrr_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input cstrr_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input cstrr_pkg::rsp_t rsp
);

  logic changing_action;

  assign changing_action = (rsp.action == cstrr_pkg::ACT_MODIFIED) ||
                           (rsp.action == cstrr_pkg::ACT_INSERTED) ||
                           (rsp.action == cstrr_pkg::ACT_REPLACED);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result item offered right after reset");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.table_changed == changing_action))
    else $error("table_changed disagrees with action");

  a_ignored_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.action == cstrr_pkg::ACT_IGNORED) |-> (rsp.slot_index == 4'd0))
    else $error("ignored item reports a slot");

  a_action_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.action <= cstrr_pkg::ACT_REPLACED))
    else $error("action code out of range");

endmodule

bind client_server_table_round_robin cstrr_checker u_cstrr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
